/* src/ted_pkg.sv */
// shared types, character codes and utf-8 helpers for the escaped-text decoder
`default_nettype none
package ted_pkg;

	localparam int Q_DEPTH  = 4;
	localparam int QPTR_W   = $clog2(Q_DEPTH);
	localparam int MAX_RES  = 4;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UP_P  = 8'h50;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_UP_W  = 8'h57;
	localparam logic [7:0] CH_UP_T  = 8'h54;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_UP_D  = 8'h44;
	localparam logic [7:0] CH_LO_C  = 8'h63;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_P  = 8'h70;

	localparam logic [15:0] SYM_DIAMETER  = 16'h2300;
	localparam logic [15:0] SYM_DEGREE    = 16'h00B0;
	localparam logic [15:0] SYM_PLUSMINUS = 16'h00B1;

	typedef enum logic [2:0] {
		M_IDLE,
		M_BS,
		M_BSU,
		M_HEX,
		M_SKIP,
		M_PCT1,
		M_PCT2
	} mode_t;

	// up to three bytes from one encoding step
	typedef struct packed {
		logic [1:0]      len;
		logic [2:0][7:0] b;
	} frag_t;

	// bytes gathered for one input item
	typedef struct packed {
		logic [2:0]              len;
		logic [MAX_RES-1:0][7:0] b;
	} acc_t;

	// one queue entry: the results of one input item
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              cnt;
		logic                    present;
		logic                    last;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic frag_t lit(input logic [7:0] c);
		frag_t f;
		f      = '0;
		f.len  = 2'd1;
		f.b[0] = c;
		return f;
	endfunction

	function automatic frag_t utf8_enc(input logic [15:0] v);
		frag_t f;
		f = '0;
		if (v == 16'd0) begin
			f.len = 2'd0;
		end else if (v < 16'h0080) begin
			f.len  = 2'd1;
			f.b[0] = v[7:0];
		end else if (v < 16'h0800) begin
			f.len  = 2'd2;
			f.b[0] = {3'b110, v[10:6]};
			f.b[1] = {2'b10, v[5:0]};
		end else begin
			f.len  = 2'd3;
			f.b[0] = {4'b1110, v[15:12]};
			f.b[1] = {2'b10, v[11:6]};
			f.b[2] = {2'b10, v[5:0]};
		end
		return f;
	endfunction

	function automatic frag_t copy_enc(input logic [7:0] c, input logic utf8_mode);
		frag_t f;
		f = '0;
		if (!utf8_mode && c[7]) begin
			f.len  = 2'd2;
			f.b[0] = {6'b110000, c[7:6]};
			f.b[1] = {2'b10, c[5:0]};
		end else begin
			f.len  = 2'd1;
			f.b[0] = c;
		end
		return f;
	endfunction

	function automatic acc_t append(input acc_t a, input frag_t f);
		acc_t r;
		r = a;
		for (int k = 0; k < 3; k++) begin
			if ((2'(k) < f.len) && (r.len < 3'(MAX_RES))) begin
				r.b[r.len[1:0]] = f.b[k];
				r.len           = r.len + 3'd1;
			end
		end
		return r;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/text_escape_decode_utf8.sv */
// top level of the escaped-text to utf-8 decoder
// an accepted byte's group goes into the queue, then its bytes into the output register
// output: one result byte per cycle while m_tready holds; an input byte yields 1 to 4
//   result bytes, or none, and is taken whenever the group queue is not full
// the serializer sets the rate: one byte of a queued group per cycle while not stalled
// reset: arst_n clears scan state, queue pointers, output valid and the mode register
`default_nettype none
module text_escape_decode_utf8 (
	input  wire        clk,
	input  wire        arst_n,
	// configuration write channel
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_data,   // [0] source_is_utf8
	// input text bytes
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,    // [7:0] in_byte
	input  wire        s_tlast,    // end_of_input
	// output utf-8 bytes
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tuser,    // [0] byte_present
	output logic       m_tlast     // end_of_output
);
	import ted_pkg::*;

	logic    utf8_mode_q;
	logic    q_push, q_pop;
	group_t  push_grp, head;
	q_stat_t q_stat;

	// configuration is always taken; a write applies from the next transaction on
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			utf8_mode_q <= cfg_data;
		end
	end

	// scanner: decodes escapes, builds at most one result group per input transaction
	ted_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.utf8_mode (utf8_mode_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_grp  (push_grp)
	);

	// group queue lets the scanner run ahead while the output side stalls
	ted_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_grp (push_grp),
		.pop      (q_pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// serializer: one byte per output transaction
	ted_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (push_grp.cnt != 3'd0 && push_grp.cnt <= 3'(MAX_RES)))
		else $error("result group with bad byte count");

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'd0))
		else $error("bare marker not a clean end of text");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_stat.full) |-> q_pop)
		else $error("push into a full queue");
`endif

endmodule
`default_nettype wire

/* src/ted_front.sv */
// front end: escape scanner, turns each input byte into a group of utf-8 bytes or none
`default_nettype none
module ted_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  utf8_mode,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,
	input  wire                  s_tlast,
	input  ted_pkg::q_stat_t     q_stat,
	output logic                 push,
	output ted_pkg::group_t      push_grp
);
	import ted_pkg::*;

	mode_t       mode_q, mode_d;
	logic [15:0] hex_val_q, hex_val_d;
	logic [2:0]  hex_cnt_q, hex_cnt_d;
	logic        hex_stop_q, hex_stop_d;
	logic        accept;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		acc_t       acc;
		logic       do_idle;
		logic       stray;
		logic [4:0] dig;
		logic [7:0] c;
		acc        = '0;
		do_idle    = 1'b0;
		stray      = 1'b0;
		c          = s_tdata;
		dig        = hex_digit(c);
		mode_d     = mode_q;
		hex_val_d  = hex_val_q;
		hex_cnt_d  = hex_cnt_q;
		hex_stop_d = hex_stop_q;

		case (mode_q)
			M_BS: begin
				mode_d = M_IDLE;
				if (c == CH_UP_P)                                    acc = append(acc, lit(CH_NL));
				else if (c == CH_TILDE)                              acc = append(acc, lit(CH_SP));
				else if (c == CH_BSL)                                acc = append(acc, lit(CH_BSL));
				else if (c == CH_UP_U)                               mode_d = M_BSU;
				else if (c == CH_UP_W || c == CH_UP_T || c == CH_UP_A) mode_d = M_SKIP;
				else begin
					acc     = append(acc, lit(CH_BSL));
					do_idle = 1'b1;
				end
			end
			M_BSU: begin
				mode_d = M_IDLE;
				if (c == CH_PLUS) begin
					mode_d     = M_HEX;
					hex_val_d  = '0;
					hex_cnt_d  = '0;
					hex_stop_d = 1'b0;
				end else begin
					acc     = append(acc, lit(CH_BSL));
					acc     = append(acc, lit(CH_UP_U));
					do_idle = 1'b1;
				end
			end
			M_HEX: begin
				if (!utf8_mode && c[7]) begin
					// a widened byte fills two character slots
					hex_stop_d = 1'b1;
					if (hex_cnt_q <= 3'd2) begin
						hex_cnt_d = hex_cnt_q + 3'd2;
					end else begin
						hex_cnt_d = 3'd4;
						stray     = 1'b1;
					end
				end else begin
					if (!hex_stop_q && dig[4]) hex_val_d = {hex_val_q[11:0], dig[3:0]};
					else                       hex_stop_d = 1'b1;
					hex_cnt_d = hex_cnt_q + 3'd1;
				end
				if (hex_cnt_d >= 3'd4) begin
					acc        = append(acc, utf8_enc(hex_val_d));
					mode_d     = M_IDLE;
					hex_val_d  = '0;
					hex_cnt_d  = '0;
					hex_stop_d = 1'b0;
					if (stray) acc = append(acc, lit({2'b10, c[5:0]}));
				end
			end
			M_SKIP: begin
				if (c == CH_SEMI) mode_d = M_IDLE;
			end
			M_PCT1: begin
				if (c == CH_PCT) begin
					mode_d = M_PCT2;
				end else begin
					acc     = append(acc, lit(CH_PCT));
					mode_d  = M_IDLE;
					do_idle = 1'b1;
				end
			end
			M_PCT2: begin
				if (c == CH_LO_C || c == CH_UP_C) begin
					acc    = append(acc, utf8_enc(SYM_DIAMETER));
					mode_d = M_IDLE;
				end else if (c == CH_LO_D || c == CH_UP_D) begin
					acc    = append(acc, utf8_enc(SYM_DEGREE));
					mode_d = M_IDLE;
				end else if (c == CH_LO_P || c == CH_UP_P) begin
					acc    = append(acc, utf8_enc(SYM_PLUSMINUS));
					mode_d = M_IDLE;
				end else if (c == CH_PCT) begin
					acc = append(acc, lit(CH_PCT));
				end else begin
					acc     = append(acc, lit(CH_PCT));
					acc     = append(acc, lit(CH_PCT));
					mode_d  = M_IDLE;
					do_idle = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		if (do_idle) begin
			if (c == CH_BSL)      mode_d = M_BS;
			else if (c == CH_PCT) mode_d = M_PCT1;
			else begin
				mode_d = M_IDLE;
				acc    = append(acc, copy_enc(c, utf8_mode));
			end
		end

		// end of text: flush whatever escape is still open
		if (s_tlast) begin
			case (mode_d)
				M_BS:   acc = append(acc, lit(CH_BSL));
				M_BSU: begin
					acc = append(acc, lit(CH_BSL));
					acc = append(acc, lit(CH_UP_U));
				end
				M_HEX:  acc = append(acc, utf8_enc(hex_val_d));
				M_PCT1: acc = append(acc, lit(CH_PCT));
				M_PCT2: begin
					acc = append(acc, lit(CH_PCT));
					acc = append(acc, lit(CH_PCT));
				end
				default: ;
			endcase
			mode_d     = M_IDLE;
			hex_val_d  = '0;
			hex_cnt_d  = '0;
			hex_stop_d = 1'b0;
		end

		push_grp.bytes = acc.b;
		push_grp.last  = s_tlast;
		if (acc.len == 3'd0) begin
			// bare end marker
			push_grp.cnt     = 3'd1;
			push_grp.present = 1'b0;
			push_grp.bytes   = '0;
		end else begin
			push_grp.cnt     = acc.len;
			push_grp.present = 1'b1;
		end
		push = accept && ((acc.len != 3'd0) || s_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			hex_val_q  <= '0;
			hex_cnt_q  <= '0;
			hex_stop_q <= 1'b0;
		end else if (accept) begin
			mode_q     <= mode_d;
			hex_val_q  <= hex_val_d;
			hex_cnt_q  <= hex_cnt_d;
			hex_stop_q <= hex_stop_d;
		end
	end

endmodule
`default_nettype wire

/* src/ted_queue.sv */
// short queue of result groups between the scanner and the serializer
`default_nettype none
module ted_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  ted_pkg::group_t      push_grp,
	input  wire                  pop,
	output ted_pkg::group_t      head,
	output ted_pkg::q_stat_t     q_stat
);
	import ted_pkg::*;

	group_t            mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   count_q;

	assign head         = mem_q[rptr_q];
	assign q_stat.full  = (count_q == (QPTR_W+1)'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)  rptr_q <= rptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/ted_back.sv */
// back end: sends each group's bytes, one per unstalled cycle, through an output register
`default_nettype none
module ted_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ted_pkg::group_t      head,
	input  ted_pkg::q_stat_t     q_stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);
	import ted_pkg::*;

	logic [1:0] idx_q;
	logic       tvalid_q;
	logic [7:0] data_q;
	logic       user_q, last_q;
	logic       load, grp_end;

	assign load    = !tvalid_q || m_tready;
	assign grp_end = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign pop     = load && !q_stat.empty && grp_end;

	assign m_tvalid = tvalid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			data_q <= head.bytes[idx_q];
			user_q <= head.present;
			last_q <= head.last && grp_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			tvalid_q <= !q_stat.empty;
			if (!q_stat.empty) idx_q <= grp_end ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire
